/* hw/rtl/pjb_pkg.sv */
// Package with shared types, codes and constants of the packet jitter buffer.
package pjb_pkg;

    localparam int SlotCountDefault = 128;
    localparam logic [15:0] InitTargetReset = 16'd50;
    localparam logic [15:0] MinTargetReset = 16'd20;
    localparam logic [15:0] MaxTargetReset = 16'd500;
    localparam logic [9:0] UsPerMs = 10'd1000;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_EXTRACT = 2'd1;
    localparam logic [1:0] MODE_UPDATE = 2'd2;

    localparam logic [1:0] REG_INIT_TARGET = 2'd0;
    localparam logic [1:0] REG_MIN_TARGET = 2'd1;
    localparam logic [1:0] REG_MAX_TARGET = 2'd2;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_BAD_SIZE = 2'd2,
        ST_NOT_READY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [31:0] sequence_number;
        logic [63:0] arrival;
        logic [31:0] handle;
        logic [15:0] size;
        logic        keyframe;
    } slot_t;

endpackage

/* hw/rtl/pjb_slot_ram.sv */
// Single-port slot descriptor memory with registered read data.
module pjb_slot_ram
    import pjb_pkg::*;
#(
    parameter int SLOT_COUNT = SlotCountDefault
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(SLOT_COUNT)-1:0] addr,
    input  slot_t                         wdata,
    output slot_t                         rdata
);

    slot_t mem [SLOT_COUNT];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* hw/rtl/packet_jitter_buffer_top.sv */
// Top level of the packet jitter buffer: slot scan sequencer, counters and register port.
// An insert of nonzero size or an extract makes one pass of the single slot memory port
// over all slots, one slot a cycle, before its result; an update, a zero-size insert and
// an unused mode go straight to the finish step. A new word is accepted
// only while the sequencer is idle, even if the previous result is still waiting.
// Valid marks are flip-flops cleared at reset, so no clearing pass is needed.
module packet_jitter_buffer_top
    import pjb_pkg::*;
#(
    parameter int SLOT_COUNT = SlotCountDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [63:0] now_us,
    input  logic [31:0] sequence_number,
    input  logic [31:0] payload_handle,
    input  logic [15:0] payload_size,
    input  logic        keyframe_in,
    input  logic [15:0] round_trip_ms,
    input  logic [15:0] jitter_estimate_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        replaced_flag,
    output logic [31:0] out_handle,
    output logic [15:0] out_size,
    output logic [31:0] out_sequence,
    output logic        out_keyframe,
    output logic [15:0] current_target_ms,
    output logic [7:0]  occupied_count,
    output logic [31:0] received_total,
    output logic [31:0] dropped_total
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [IW:0] LastIdx = (IW + 1)'(SLOT_COUNT - 1);
    localparam logic [IW:0] EndIdx = (IW + 1)'(SLOT_COUNT);

    state_t state_reg, state_next;

    logic [15:0] init_reg, min_reg, max_reg;
    logic [15:0] target_reg;
    logic [CW-1:0] count_reg;
    logic [31:0] recv_reg, drop_reg;
    logic [SLOT_COUNT-1:0] valid_reg;

    logic [1:0]  mode_reg;
    logic [63:0] now_reg;
    logic [31:0] seq_reg, handle_reg;
    logic [15:0] size_reg, rtt_reg, jit_reg;
    logic        key_reg;
    logic [25:0] thr_reg;

    logic [IW:0]   issue_reg;
    logic          pend_reg;
    logic [IW-1:0] idx_reg;
    logic          vbit_reg;

    logic          dup_reg, free_found_reg, best_found_reg;
    logic [IW-1:0] free_idx_reg, best_idx_reg;
    logic [63:0]   best_arr_reg;
    slot_t         best_slot_reg;

    logic        out_valid_reg;
    status_t     status_reg;
    logic        replaced_reg;
    logic [31:0] out_handle_reg, out_seq_reg;
    logic [15:0] out_size_reg;
    logic        out_key_reg;

    logic          ram_we;
    logic [IW-1:0] ram_addr;
    slot_t         ram_wdata, ram_rdata;

    logic in_fire, cfg_write, out_free, commit, last_proc;
    logic [63:0] waited;
    logic candidate;
    logic [17:0] goal;
    logic [16:0] avg;
    logic [IW-1:0] ins_idx;
    logic ins_ok;

    pjb_slot_ram #(.SLOT_COUNT(SLOT_COUNT)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign in_stall = (state_reg != S_IDLE);
    assign in_fire = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign commit = (state_reg == S_FINISH) && out_free;
    assign last_proc = pend_reg && ({1'b0, idx_reg} == LastIdx);

    always_comb
    begin
        unique case (paddr[3:2])
            REG_INIT_TARGET: prdata = {16'd0, init_reg};
            REG_MIN_TARGET:  prdata = {16'd0, min_reg};
            REG_MAX_TARGET:  prdata = {16'd0, max_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        waited = now_reg - ram_rdata.arrival;
        if (mode_reg == MODE_EXTRACT)
        begin
            candidate = vbit_reg && (waited >= {38'd0, thr_reg});
        end
        else
        begin
            candidate = 1'b1;
        end
        goal = {2'b00, rtt_reg} + {1'b0, jit_reg, 1'b0};
        if (goal < {2'b00, min_reg})
        begin
            goal = {2'b00, min_reg};
        end
        if (goal > {2'b00, max_reg})
        begin
            goal = {2'b00, max_reg};
        end
        avg = ({1'b0, target_reg} + {1'b0, goal[15:0]}) >> 1;
        ins_idx = free_found_reg ? free_idx_reg : best_idx_reg;
        ins_ok = (mode_reg == MODE_INSERT) && (size_reg != 16'd0) && !dup_reg;
        ram_we = commit && ins_ok;
        ram_addr = ram_we ? ins_idx : issue_reg[IW-1:0];
        ram_wdata.sequence_number = seq_reg;
        ram_wdata.arrival = now_reg;
        ram_wdata.handle = handle_reg;
        ram_wdata.size = size_reg;
        ram_wdata.keyframe = key_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (mode == MODE_EXTRACT || (mode == MODE_INSERT && payload_size != 16'd0))
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN:
            begin
                if (last_proc)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= InitTargetReset;
            min_reg <= MinTargetReset;
            max_reg <= MaxTargetReset;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_INIT_TARGET: init_reg <= pwdata[15:0];
                REG_MIN_TARGET:  min_reg <= pwdata[15:0];
                REG_MAX_TARGET:  max_reg <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg <= mode;
            now_reg <= now_us;
            seq_reg <= sequence_number;
            handle_reg <= payload_handle;
            size_reg <= payload_size;
            key_reg <= keyframe_in;
            rtt_reg <= round_trip_ms;
            jit_reg <= jitter_estimate_ms;
            thr_reg <= {10'd0, target_reg} * {16'd0, UsPerMs};
        end
        idx_reg <= issue_reg[IW-1:0];
        vbit_reg <= valid_reg[issue_reg[IW-1:0]];
        if (pend_reg && candidate && (!best_found_reg || ram_rdata.arrival < best_arr_reg))
        begin
            best_idx_reg <= idx_reg;
            best_arr_reg <= ram_rdata.arrival;
            best_slot_reg <= ram_rdata;
        end
        if (pend_reg && !vbit_reg && !free_found_reg)
        begin
            free_idx_reg <= idx_reg;
        end
        if (commit)
        begin
            replaced_reg <= 1'b0;
            out_handle_reg <= 32'd0;
            out_size_reg <= 16'd0;
            out_seq_reg <= 32'd0;
            out_key_reg <= 1'b0;
            status_reg <= ST_DONE;
            if (mode_reg == MODE_INSERT)
            begin
                if (size_reg == 16'd0)
                begin
                    status_reg <= ST_BAD_SIZE;
                end
                else if (dup_reg)
                begin
                    status_reg <= ST_DUPLICATE;
                end
                else
                begin
                    replaced_reg <= !free_found_reg;
                end
            end
            else if (mode_reg == MODE_EXTRACT)
            begin
                if (best_found_reg)
                begin
                    out_handle_reg <= best_slot_reg.handle;
                    out_size_reg <= best_slot_reg.size;
                    out_seq_reg <= best_slot_reg.sequence_number;
                    out_key_reg <= best_slot_reg.keyframe;
                end
                else
                begin
                    status_reg <= ST_NOT_READY;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg <= '0;
            pend_reg <= 1'b0;
            dup_reg <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
            target_reg <= InitTargetReset;
            count_reg <= '0;
            recv_reg <= 32'd0;
            drop_reg <= 32'd0;
            valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                issue_reg <= '0;
                pend_reg <= 1'b0;
                dup_reg <= 1'b0;
                free_found_reg <= 1'b0;
                best_found_reg <= 1'b0;
            end
            else if (state_reg == S_SCAN)
            begin
                pend_reg <= (issue_reg != EndIdx);
                if (issue_reg != EndIdx)
                begin
                    issue_reg <= issue_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (vbit_reg && ram_rdata.sequence_number == seq_reg)
                    begin
                        dup_reg <= 1'b1;
                    end
                    if (!vbit_reg)
                    begin
                        free_found_reg <= 1'b1;
                    end
                    if (candidate)
                    begin
                        best_found_reg <= 1'b1;
                    end
                end
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                if (mode_reg == MODE_UPDATE)
                begin
                    target_reg <= avg[15:0];
                end
                if (ins_ok)
                begin
                    valid_reg[ins_idx] <= 1'b1;
                    recv_reg <= recv_reg + 32'd1;
                    if (free_found_reg)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    else
                    begin
                        drop_reg <= drop_reg + 32'd1;
                    end
                end
                if (mode_reg == MODE_EXTRACT && best_found_reg)
                begin
                    valid_reg[best_idx_reg] <= 1'b0;
                    count_reg <= count_reg - 1'b1;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign replaced_flag = replaced_reg;
    assign out_handle = out_handle_reg;
    assign out_size = out_size_reg;
    assign out_sequence = out_seq_reg;
    assign out_keyframe = out_key_reg;
    assign current_target_ms = target_reg;
    assign occupied_count = 8'(count_reg);
    assign received_total = recv_reg;
    assign dropped_total = drop_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SLOT_COUNT))
        else $error("occupied count exceeds slot count");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result word raised outside the finish step");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> in_stall)
        else $error("input not stalled after an accepted word");

    a_count_matches_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ($countones(valid_reg) == int'(count_reg)))
        else $error("occupied count differs from valid marks");

endmodule
